// File: rtl/chs_pkg.sv
// Shared types and constants for the chained hash set core.
// Holds the key layout, the hash unit status struct and the request codes.
// No dependencies.
`default_nettype none

package chs_pkg;

    // Key layout: bytes 0 to 7 in the lower word, byte 8 in the upper byte.
    localparam int BYTE_W        = 8;
    localparam int KEY_LO_W      = 64;
    localparam int KEY_HI_W      = 8;
    localparam int MAX_KEY_BYTES = 9;

    // Byte sum of a full key is at most 9 * 255, which fits in 12 bits.
    localparam int SUM_W = 12;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;

    // Request codes.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic [KEY_HI_W-1:0] hi;
        logic [KEY_LO_W-1:0] lo;
    } chs_key_t;

    // Status of the hash unit toward the controller.
    typedef struct packed {
        logic     done;
        chs_key_t key;
    } chs_hash_out_t;

endpackage

`default_nettype wire

// File: rtl/chs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the bucket heads and for the entry pool. No dependencies.
`default_nettype none

module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; the read sees the old contents
    // when both hit the same address in one cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/chs_hash.sv
// Key normalizer and bucket hash: cuts the key at its first zero byte, sums
// the bytes and reduces the sum modulo BUCKETS in a three-stage pipeline.
// Depends on chs_pkg.
`default_nettype none

module chs_hash
    import chs_pkg::*;
#(
    parameter int BUCKETS   = 5,
    parameter int KEY_BYTES = 9
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [KEY_LO_W-1:0]         key_low,
    input  wire logic [KEY_HI_W-1:0]         key_high,
    output chs_hash_out_t                    status,
    output logic      [$clog2(BUCKETS)-1:0]  bucket
);

    localparam int BW      = $clog2(BUCKETS);
    // Reciprocal multiply: q = (sum * MAGIC) >> SHIFT is the exact quotient
    // for every sum below 2**SUM_W.
    localparam int SHIFT   = SUM_W + $clog2(BUCKETS);
    localparam int MAGIC_W = SUM_W + 2;
    localparam int PROD_W  = SHIFT + SUM_W;
    localparam logic [MAGIC_W-1:0] MAGIC     = MAGIC_W'((2**SHIFT + BUCKETS - 1) / BUCKETS);
    localparam logic [SUM_W-1:0]   BUCKETS_C = SUM_W'(BUCKETS);

    chs_key_t          key_norm;
    logic [SUM_W-1:0]  sum_comb;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  qb;
    logic [SUM_W-1:0]  rem;
    logic [SUM_W-1:0]  rem_fix;

    logic              v1_reg, v2_reg, v3_reg;
    chs_key_t          key_reg;
    logic [SUM_W-1:0]  sum1_reg, sum2_reg;
    logic [SUM_W-1:0]  quot_reg;
    logic [BW-1:0]     bucket_reg;

    // Keep bytes up to the first zero byte and within KEY_BYTES; sum them.
    always_comb begin
        logic              alive;
        logic [BYTE_W-1:0] b;
        alive    = 1'b1;
        key_norm = '0;
        sum_comb = '0;
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            if (i < 8) begin
                b = key_low[i*BYTE_W +: BYTE_W];
            end else begin
                b = key_high;
            end
            alive = alive && (b != '0) && (i < KEY_BYTES);
            if (alive) begin
                if (i < 8) begin
                    key_norm.lo[i*BYTE_W +: BYTE_W] = b;
                end else begin
                    key_norm.hi = b;
                end
                sum_comb = sum_comb + SUM_W'(b);
            end
        end
    end

    // Quotient estimate and remainder with a final compare and subtract.
    assign prod    = PROD_W'(sum1_reg) * PROD_W'(MAGIC);
    assign qb      = quot_reg * BUCKETS_C;
    assign rem     = sum2_reg - qb;
    assign rem_fix = (rem >= BUCKETS_C) ? (rem - BUCKETS_C) : rem;

    // Pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Pipeline payload; the key and bucket hold until the next start.
    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg  <= key_norm;
            sum1_reg <= sum_comb;
        end
        if (v1_reg) begin
            quot_reg <= prod[SHIFT +: SUM_W];
            sum2_reg <= sum1_reg;
        end
        if (v2_reg) begin
            bucket_reg <= rem_fix[BW-1:0];
        end
    end

    assign status.done = v3_reg;
    assign status.key  = key_reg;
    assign bucket      = bucket_reg;

endmodule

`default_nettype wire

// File: rtl/chained_hash_set_core.sv
// Top level of the chained hash set: stream ports, request sequencer and the
// bucket-head and entry-pool memories. Depends on chs_pkg, chs_hash, chs_ram.
//
// A set of short string keys kept in a hash table with separate chaining.
// Each input transaction inserts or searches one key of up to nine nonzero
// bytes (the key ends at its first zero byte); each produces exactly one
// output transaction with found, inserted and table_full. The block handles
// one request at a time: from acceptance it steps through S_HASH, S_HEAD,
// S_WALK (skipped for an empty chain, else up to ENTRIES entries), S_DECIDE
// and S_OUT, which waits while the previous result still waits on m_tready;
// it takes a new request only in S_IDLE. The walk reads one entry per cycle
// from the registered-read entry memory. New keys take entries of
// the pool in order and go to the head of their chain; once ENTRIES keys are
// held, inserts of new keys are refused with table_full. No clearing pass is
// needed after reset: bucket heads carry valid flags that reset clears.
`default_nettype none

module chained_hash_set_core
    import chs_pkg::*;
#(
    parameter int BUCKETS   = 5,
    parameter int ENTRIES   = 32,
    parameter int KEY_BYTES = 9
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata: action [0], key_low [64:1], key_high [72:65], zero [79:73]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata: found [0], inserted [1], table_full [2], zero [7:3]
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int AW    = $clog2(ENTRIES);
    localparam int IDX_W = $clog2(ENTRIES + 1);
    localparam int ENT_W = KEY_LO_W + KEY_HI_W + IDX_W;
    localparam logic [IDX_W-1:0] ENTRIES_C = IDX_W'(ENTRIES);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HASH   = 3'd1;
    localparam logic [2:0] S_HEAD   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic                 action_reg, action_next;
    logic [IDX_W-1:0]     node_reg, node_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     steps_reg, steps_next;
    logic [IDX_W-1:0]     used_reg, used_next;
    logic [BUCKETS-1:0]   head_valid_reg, head_valid_next;
    logic                 found_reg, found_next;
    logic                 inserted_reg, inserted_next;
    logic                 full_reg, full_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 accept;
    chs_hash_out_t        hstat;
    logic [BW-1:0]        hbucket;
    logic [IDX_W-1:0]     head_rdata;
    logic [IDX_W-1:0]     head_node;
    logic [ENT_W-1:0]     ent_rdata;
    logic [ENT_W-1:0]     ent_wdata;
    logic [AW-1:0]        ent_raddr;
    logic [IDX_W-1:0]     walk_next;
    logic [IDX_W-1:0]     steps_inc;
    logic                 key_match;
    logic                 do_insert;
    logic                 pool_empty;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Key normalizer and bucket reduction.
    chs_hash #(
        .BUCKETS  (BUCKETS),
        .KEY_BYTES(KEY_BYTES)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key_low (s_tdata[KEY_LO_W:1]),
        .key_high(s_tdata[KEY_LO_W+KEY_HI_W:KEY_LO_W+1]),
        .status  (hstat),
        .bucket  (hbucket)
    );

    // Bucket heads, addressed by the bucket of the current request.
    chs_ram #(
        .WIDTH(IDX_W),
        .DEPTH(BUCKETS)
    ) u_head_ram (
        .aclk   (aclk),
        .wr_en  (do_insert),
        .wr_addr(hbucket),
        .wr_data(used_reg),
        .rd_addr(hbucket),
        .rd_data(head_rdata)
    );

    // Entry pool: {next, key_high, key_low} per entry.
    chs_ram #(
        .WIDTH(ENT_W),
        .DEPTH(ENTRIES)
    ) u_entry_ram (
        .aclk   (aclk),
        .wr_en  (do_insert),
        .wr_addr(used_reg[AW-1:0]),
        .wr_data(ent_wdata),
        .rd_addr(ent_raddr),
        .rd_data(ent_rdata)
    );

    assign ent_wdata = {head_reg, hstat.key.hi, hstat.key.lo};

    // A head that was never written reads as the empty marker.
    assign head_node = head_valid_reg[hbucket] ? head_rdata : ENTRIES_C;

    // Chain walk compare and next link.
    assign key_match = (ent_rdata[KEY_LO_W-1:0] == hstat.key.lo) &&
                       (ent_rdata[KEY_LO_W+KEY_HI_W-1:KEY_LO_W] == hstat.key.hi);
    assign walk_next = ent_rdata[ENT_W-1:KEY_LO_W+KEY_HI_W];
    assign steps_inc = steps_reg + 1'b1;
    assign ent_raddr = (state_reg == S_HEAD) ? head_node[AW-1:0] : walk_next[AW-1:0];

    // Insert decision; only one request is in flight, so memory writes always
    // land before the next request reads.
    assign pool_empty = (used_reg >= ENTRIES_C);
    assign do_insert  = (state_reg == S_DECIDE) && (action_reg == ACT_INSERT) &&
                        !found_reg && !pool_empty;

    // Request sequencer.
    always_comb begin
        state_next      = state_reg;
        action_next     = action_reg;
        node_next       = node_reg;
        head_next       = head_reg;
        steps_next      = steps_reg;
        used_next       = used_reg;
        head_valid_next = head_valid_reg;
        found_next      = found_reg;
        inserted_next   = inserted_reg;
        full_next       = full_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    action_next   = s_tdata[0];
                    found_next    = 1'b0;
                    inserted_next = 1'b0;
                    full_next     = 1'b0;
                    state_next    = S_HASH;
                end
            end
            S_HASH: begin
                if (hstat.done) begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                node_next  = head_node;
                head_next  = head_node;
                steps_next = '0;
                if (head_node >= ENTRIES_C) begin
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (key_match) begin
                    found_next = 1'b1;
                    state_next = S_DECIDE;
                end else begin
                    steps_next = steps_inc;
                    node_next  = walk_next;
                    if ((walk_next >= ENTRIES_C) || (steps_inc == ENTRIES_C)) begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (do_insert) begin
                    used_next                = used_reg + 1'b1;
                    head_valid_next[hbucket] = 1'b1;
                    inserted_next            = 1'b1;
                end else if ((action_reg == ACT_INSERT) && !found_reg) begin
                    full_next = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W-3){1'b0}}, full_reg, inserted_reg, found_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            head_valid_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            head_valid_reg <= head_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Request payload and result register.
    always_ff @(posedge aclk) begin
        action_reg   <= action_next;
        node_reg     <= node_next;
        head_reg     <= head_next;
        steps_reg    <= steps_next;
        found_reg    <= found_next;
        inserted_reg <= inserted_next;
        full_reg     <= full_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The pool count never passes the pool size.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= ENTRIES_C)
        else $error("entry count exceeds pool size");

    // Every insert takes exactly the next entry of the pool.
    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("entry count did not advance on insert");

    // The walk only visits entries inside the pool.
    a_walk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (node_reg < used_reg))
        else $error("chain walk left the written part of the pool");

    // A search never changes the table or reports a refusal.
    a_search_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DECIDE) && (action_reg == ACT_SEARCH)) |=>
            (!inserted_reg && !full_reg))
        else $error("search reported an insert or a full table");

    // At most one result flag is set.
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ($countones(m_tdata_reg[2:0]) <= 1))
        else $error("result flags not mutually exclusive");

endmodule

`default_nettype wire

// File: test/chained_hash_set_tb.sv
// Testbench for chained_hash_set_core: directed and random insert and search traffic
// checked against a scoreboard that keeps its own copy of the hash table.
// Depends on chs_pkg and the chained_hash_set_core RTL.
`timescale 1ns / 100ps

import chs_pkg::*;

// One result transaction, found in the lowest bit as on m_tdata.
typedef struct packed {
    logic table_full;
    logic inserted;
    logic found;
} set_status_t;

// Shadow hash table and the queue of statuses still owed by the block.
class hash_set_scoreboard #(int BUCKETS = 5, int ENTRIES = 32, int KEY_BYTES = 9);
    int                  chain_head    [BUCKETS];
    logic [KEY_LO_W-1:0] stored_lo     [ENTRIES];
    logic [KEY_HI_W-1:0] stored_hi     [ENTRIES];
    int                  next_in_chain [ENTRIES];
    int                  entries_taken;
    set_status_t         expected_status [$];
    int                  failures;

    function new();
        for (int b = 0; b < BUCKETS; b++)
            chain_head[b] = ENTRIES;
        entries_taken = 0;
        failures      = 0;
    endfunction

    // Apply one accepted request to the shadow table and queue its status.
    function void record_request(logic act, logic [KEY_LO_W-1:0] raw_lo,
                                 logic [KEY_HI_W-1:0] raw_hi);
        logic [KEY_LO_W-1:0] lo;
        logic [KEY_HI_W-1:0] hi;
        logic [7:0]          b;
        bit                  ended;
        int                  sum;
        int                  bucket;
        int                  node;
        int                  steps;
        set_status_t         st;
        lo    = '0;
        hi    = '0;
        sum   = 0;
        ended = 1'b0;
        // The key stops at its first zero byte or at KEY_BYTES.
        for (int i = 0; i < KEY_BYTES && i < MAX_KEY_BYTES; i++) begin
            b = (i < 8) ? raw_lo[8*i +: 8] : raw_hi;
            if (b == 8'd0)
                ended = 1'b1;
            if (!ended) begin
                if (i < 8)
                    lo[8*i +: 8] = b;
                else
                    hi = b;
                sum += b;
            end
        end
        bucket = sum % BUCKETS;
        node   = chain_head[bucket];
        steps  = 0;
        st     = '0;
        // Walk the chain from its head until a match or its end.
        while (node < ENTRIES && steps < ENTRIES && !st.found) begin
            if (stored_lo[node] == lo && stored_hi[node] == hi)
                st.found = 1'b1;
            else begin
                node = next_in_chain[node];
                steps++;
            end
        end
        // A new key takes the next pool entry and becomes the chain head.
        if (act == ACT_INSERT && !st.found) begin
            if (entries_taken < ENTRIES) begin
                stored_lo[entries_taken]     = lo;
                stored_hi[entries_taken]     = hi;
                next_in_chain[entries_taken] = chain_head[bucket];
                chain_head[bucket]           = entries_taken;
                entries_taken++;
                st.inserted = 1'b1;
            end else begin
                st.table_full = 1'b1;
            end
        end
        expected_status.push_back(st);
    endfunction

    // Compare one result transaction with the oldest queued status.
    function void check_status(set_status_t got);
        set_status_t want;
        if (expected_status.size() == 0) begin
            $display("%0t: result with none pending, expected none, actual %b",
                     $time, got);
            failures++;
            return;
        end
        want = expected_status.pop_front();
        if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %b, actual %b",
                     $time, want.found, got.found);
            failures++;
        end
        if (got.inserted !== want.inserted) begin
            $display("%0t: inserted mismatch, expected %b, actual %b",
                     $time, want.inserted, got.inserted);
            failures++;
        end
        if (got.table_full !== want.table_full) begin
            $display("%0t: table_full mismatch, expected %b, actual %b",
                     $time, want.table_full, got.table_full);
            failures++;
        end
    endfunction
endclass

module tb;
    localparam int BUCKETS     = 5;
    localparam int ENTRIES     = 32;
    localparam int KEY_BYTES   = 9;
    localparam int LIB_KEYS    = 56;
    localparam int CROWD_KEYS  = 24;
    localparam int CROWD_SLOT  = 3;
    localparam int FILL_ITEMS  = 300;
    localparam int MIXED_ITEMS = 1300;
    localparam int HOLD_AFTER  = 700;
    localparam int HOLD_CYCLES = 400;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata: action [0], key_low [64:1], key_high [72:65], zero [79:73]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata: found [0], inserted [1], table_full [2], zero [7:3]
    logic [M_TDATA_W-1:0] m_tdata;

    hash_set_scoreboard #(BUCKETS, ENTRIES, KEY_BYTES) sb;

    int                  requests_sent = 0;
    int                  burst_left    = 0;
    logic [KEY_LO_W-1:0] lib_lo  [LIB_KEYS];
    logic [KEY_HI_W-1:0] lib_hi  [LIB_KEYS];
    int                  lib_len [LIB_KEYS];

    chained_hash_set_core #(
        .BUCKETS   (BUCKETS),
        .ENTRIES   (ENTRIES),
        .KEY_BYTES (KEY_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offer one request and hold it until the block takes it; requests come
    // in bursts of random length separated by random gaps.
    task automatic drive_request(input logic act, input logic [KEY_LO_W-1:0] lo,
                                 input logic [KEY_HI_W-1:0] hi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - KEY_HI_W - KEY_LO_W - 1){1'b0}}, hi, lo, act};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        sb.record_request(act, lo, hi);
    endtask

    // Send a stored key, sometimes with random bytes after its zero byte.
    task automatic send_library_key(input logic act, input int idx);
        logic [KEY_LO_W-1:0] lo;
        logic [KEY_HI_W-1:0] hi;
        lo = lib_lo[idx];
        hi = lib_hi[idx];
        if (lib_len[idx] < MAX_KEY_BYTES - 1 && $urandom_range(1) == 1) begin
            for (int i = lib_len[idx] + 1; i < MAX_KEY_BYTES; i++) begin
                if (i < 8)
                    lo[8*i +: 8] = 8'($urandom);
                else
                    hi = 8'($urandom);
            end
        end
        drive_request(act, lo, hi);
    endtask

    // Result acceptance and checking.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_status(set_status_t'(m_tdata[2:0]));
    end

    // Receiver: stall density changes from stretch to stretch, and once the
    // output is held off long enough for the block to stall its input.
    initial begin : receiver
        int stall_pct;
        bit held_off;
        held_off = 1'b0;
        forever begin
            case ($urandom_range(3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat ($urandom_range(80, 8)) begin
                @(posedge aclk);
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
            if (!held_off && requests_sent >= HOLD_AFTER) begin
                held_off = 1'b1;
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        logic [KEY_LO_W-1:0] lo;
        logic [KEY_HI_W-1:0] hi;
        logic [7:0]          b;
        int                  len;
        int                  sum;
        int                  r;
        int                  slot;
        sb = new();

        // Key library: many keys crowd one bucket to grow a long chain.
        for (int k = 0; k < LIB_KEYS; k++) begin
            len  = (k == 0) ? 0 : $urandom_range(MAX_KEY_BYTES, 1);
            slot = (k > 0 && k <= CROWD_KEYS) ? CROWD_SLOT : -1;
            lo   = '0;
            hi   = '0;
            sum  = 0;
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom_range(255, 1));
                // Nudge the last byte so the sum lands in the chosen bucket.
                if (i == len - 1 && slot >= 0) begin
                    r = ((sum + b) % BUCKETS - slot + BUCKETS) % BUCKETS;
                    b = (b > r) ? 8'(b - r) : 8'(b + BUCKETS - r);
                end
                if (i < 8)
                    lo[8*i +: 8] = b;
                else
                    hi = b;
                sum += b;
            end
            lib_lo[k]  = lo;
            lib_hi[k]  = hi;
            lib_len[k] = len;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty key, then the empty key again with trailing garbage.
        drive_request(ACT_SEARCH, '0, '0);
        drive_request(ACT_INSERT, '0, '0);
        drive_request(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 8'hFF);
        // Full nine-byte keys at both byte extremes.
        drive_request(ACT_SEARCH, '1, '1);
        drive_request(ACT_INSERT, '1, '1);
        drive_request(ACT_INSERT, '1, '1);
        drive_request(ACT_SEARCH, '1, '1);
        drive_request(ACT_INSERT, 64'h0101_0101_0101_0101, 8'h01);
        // An eight-byte prefix of a stored key is a different key.
        drive_request(ACT_SEARCH, '1, '0);
        drive_request(ACT_INSERT, '1, '0);
        // Seven-byte key with different bytes after its zero byte, then two near misses.
        drive_request(ACT_SEARCH, 64'h00FF_FFFF_FFFF_FFFF, 8'hAA);
        drive_request(ACT_INSERT, 64'h00FF_FFFF_FFFF_FFFF, 8'h55);
        drive_request(ACT_SEARCH, 64'h33FF_FFFF_FFFF_FFFF, 8'h00);
        drive_request(ACT_SEARCH, 64'h007F_FFFF_FFFF_FFFF, 8'h00);
        // One-byte key with garbage, found again in clean form.
        drive_request(ACT_INSERT, 64'h1234_5678_9ABC_0080, 8'hC3);
        drive_request(ACT_SEARCH, 64'h0000_0000_0000_0080, 8'h00);
        drive_request(ACT_INSERT, 64'h0000_0000_0000_0080, 8'h00);

        // Fill phase: mostly searches while the pool still has room.
        repeat (FILL_ITEMS)
            send_library_key(($urandom_range(99) < 15) ? ACT_INSERT : ACT_SEARCH,
                             $urandom_range(LIB_KEYS - 1));

        // Mixed phase: pool exhausted, library keys plus random noise keys.
        repeat (MIXED_ITEMS) begin
            if ($urandom_range(99) < 15)
                drive_request($urandom_range(1) ? ACT_SEARCH : ACT_INSERT,
                              {$urandom, $urandom}, 8'($urandom));
            else
                send_library_key($urandom_range(1) ? ACT_SEARCH : ACT_INSERT,
                                 $urandom_range(LIB_KEYS - 1));
        end

        s_tvalid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(posedge aclk);
        // Longest walk plus margin, to catch any stray result.
        repeat (2 * ENTRIES) @(posedge aclk);
        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end
endmodule
